[rtl/gbos_pkg.sv]
// ----------------------------------------------------------------------------
// gbos_pkg
// Shared types and constants for the greedy box overlap suppression block.
// ----------------------------------------------------------------------------
package gbos_pkg;

    // kept store geometry
    localparam int MAX_KEPT = 64;
    localparam int KEPT_AW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W    = $clog2(MAX_KEPT + 1);

    // field widths
    localparam int COORD_W  = 16;
    localparam int AREA_W   = 2 * COORD_W;
    localparam int THR_W    = 16;
    localparam int INDEX_W  = 12;
    localparam int TOTAL_W  = 7;

    // threshold reset: 0.45 in Q0.16, truncated
    localparam logic [THR_W-1:0]   THRESH_RESET = 16'd29491;
    localparam logic [INDEX_W-1:0] INDEX_MAX    = 12'd4095;

    // one box in Q12.4
    typedef struct packed {
        logic [COORD_W-1:0]        height;
        logic [COORD_W-1:0]        width;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] left;
    } box_t;

    // one entry of the kept store
    typedef struct packed {
        logic [AREA_W-1:0] area;
        box_t              box;
    } kept_entry_t;

    // status from the compare unit back to the sequencer
    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } unit_stat_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

endpackage

[rtl/gbos_ram.sv]
// ----------------------------------------------------------------------------
// gbos_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/gbos_overlap_unit.sv]
// ----------------------------------------------------------------------------
// gbos_overlap_unit
// Pipelined IoU test of the candidate box against one kept entry per cycle:
// overlap lengths, intersection, union, threshold product, compare.
// ----------------------------------------------------------------------------
module gbos_overlap_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         entry_valid,
    input  gbos_pkg::kept_entry_t        entry,
    input  gbos_pkg::box_t               cand,
    input  logic [gbos_pkg::AREA_W-1:0]  cand_area,
    input  logic [gbos_pkg::THR_W-1:0]   thr,
    output gbos_pkg::unit_stat_t         stat
);
    import gbos_pkg::*;

    localparam int EXT_W  = COORD_W + 2;
    localparam int UNI_W  = AREA_W + 1;
    localparam int PROD_W = THR_W + UNI_W;

    // overlap of [a0, a0+alen) and [b0, b0+blen), zero if none
    function automatic logic [COORD_W-1:0] overlap_len(
        input logic signed [COORD_W-1:0] a0,
        input logic [COORD_W-1:0]        alen,
        input logic signed [COORD_W-1:0] b0,
        input logic [COORD_W-1:0]        blen
    );
        logic signed [EXT_W-1:0] a0_x;
        logic signed [EXT_W-1:0] b0_x;
        logic signed [EXT_W-1:0] a1;
        logic signed [EXT_W-1:0] b1;
        logic signed [EXT_W-1:0] lo;
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] diff;
        a0_x = EXT_W'(a0);
        b0_x = EXT_W'(b0);
        a1   = a0_x + $signed({2'b00, alen});
        b1   = b0_x + $signed({2'b00, blen});
        lo   = (a0_x > b0_x) ? a0_x : b0_x;
        hi   = (a1 < b1) ? a1 : b1;
        diff = hi - lo;
        overlap_len = (hi > lo) ? diff[COORD_W-1:0] : '0;
    endfunction

    logic                v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [COORD_W-1:0]  iw_reg, ih_reg;
    logic [COORD_W-1:0]  iw_next, ih_next;
    logic [AREA_W-1:0]   karea1_reg, karea2_reg;
    logic [AREA_W-1:0]   inter2_reg, inter3_reg, inter4_reg;
    logic [UNI_W-1:0]    uni3_reg;
    logic [PROD_W-1:0]   prod4_reg;
    logic                hit5_reg;

    // stage 1 overlap lengths
    always_comb
    begin
        iw_next = overlap_len(cand.left, cand.width, entry.box.left, entry.box.width);
        ih_next = overlap_len(cand.top, cand.height, entry.box.top, entry.box.height);
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= entry_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        iw_reg     <= iw_next;
        ih_reg     <= ih_next;
        karea1_reg <= entry.area;
        // intersection area
        inter2_reg <= AREA_W'(iw_reg) * AREA_W'(ih_reg);
        karea2_reg <= karea1_reg;
        // union, never negative since inter fits in both areas
        uni3_reg   <= {1'b0, cand_area} + {1'b0, karea2_reg} - {1'b0, inter2_reg};
        inter3_reg <= inter2_reg;
        // threshold times union
        prod4_reg  <= PROD_W'(thr) * PROD_W'(uni3_reg);
        inter4_reg <= inter3_reg;
        // inter * 65536 against threshold * union
        hit5_reg   <= PROD_W'({inter4_reg, 16'h0000}) > prod4_reg;
    end

    assign stat.busy      = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
    assign stat.hit_valid = v5_reg;
    assign stat.hit       = hit5_reg;

endmodule

[rtl/greedy_box_overlap_suppression_top.sv]
// ----------------------------------------------------------------------------
// greedy_box_overlap_suppression_top
// Greedy non-maximum suppression by IoU over boxes sorted by falling score.
// ----------------------------------------------------------------------------
// One box is taken at a time. After acceptance the sequencer streams the kept
// store of the current frame through a pipelined compare unit, one kept box
// per cycle, so the time from acceptance to a box's result beat grows with the
// number of boxes already kept (an empty store needs no compare); the single
// read port of the kept store and the five-stage compare pipeline set that
// time. The result sits in an output register, so the next box is taken as
// soon as the sequencer is idle, even while the previous result waits. The
// threshold register may be written only while no box is in flight.
module greedy_box_overlap_suppression_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // threshold register
    input  logic                               cfg_wr_en,
    input  logic [gbos_pkg::THR_W-1:0]         cfg_wr_data,
    // box input
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               first_of_frame,
    input  logic signed [gbos_pkg::COORD_W-1:0] box_left,
    input  logic signed [gbos_pkg::COORD_W-1:0] box_top,
    input  logic [gbos_pkg::COORD_W-1:0]       box_width,
    input  logic [gbos_pkg::COORD_W-1:0]       box_height,
    // result output
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               keep,
    output logic [gbos_pkg::INDEX_W-1:0]       box_index,
    output logic [gbos_pkg::TOTAL_W-1:0]       kept_total,
    output logic                               store_overflow
);
    import gbos_pkg::*;

    state_t              state_reg, state_next;
    logic [THR_W-1:0]    thr_reg;
    box_t                cand_reg;
    logic [AREA_W-1:0]   cand_area_reg;
    logic [CNT_W-1:0]    kept_count_reg, kept_count_next;
    logic [INDEX_W-1:0]  box_counter_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [CNT_W-1:0]    scan_cnt_reg;
    logic                suppress_reg;
    logic                rd_valid_reg;
    logic                out_valid_reg;
    logic                keep_reg;
    logic [INDEX_W-1:0]  box_index_reg;
    logic [TOTAL_W-1:0]  kept_total_reg;
    logic                overflow_reg;

    logic                accept;
    logic                issue;
    logic                finish;
    logic                keep_now;
    logic                store_now;
    logic [INDEX_W-1:0]  idx_base;
    kept_entry_t         wr_entry;
    kept_entry_t         rd_entry;
    unit_stat_t          stat;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        issue      = 1'b0;
        finish     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg < kept_count_reg)
                begin
                    issue = 1'b1;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_valid_reg && !stat.busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign accept    = in_valid && in_ready;
    assign keep_now  = !suppress_reg;
    assign store_now = keep_now && (kept_count_reg < CNT_W'(MAX_KEPT));
    assign idx_base  = first_of_frame ? '0 : box_counter_reg;

    // kept count after this box
    always_comb
    begin
        kept_count_next = kept_count_reg;
        if (accept && first_of_frame)
        begin
            kept_count_next = '0;
        end
        else if (finish && store_now)
        begin
            kept_count_next = kept_count_reg + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            thr_reg         <= THRESH_RESET;
            kept_count_reg  <= '0;
            box_counter_reg <= '0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            suppress_reg    <= 1'b0;
            scan_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            kept_count_reg <= kept_count_next;
            rd_valid_reg   <= issue;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                box_counter_reg <= (idx_base < INDEX_MAX) ? idx_base + 1'b1 : idx_base;
                scan_cnt_reg    <= '0;
                suppress_reg    <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (stat.hit_valid && stat.hit)
                begin
                    suppress_reg <= 1'b1;
                end
            end
            // output beat handshake
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // candidate and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cand_reg.left   <= box_left;
            cand_reg.top    <= box_top;
            cand_reg.width  <= box_width;
            cand_reg.height <= box_height;
            cand_area_reg   <= AREA_W'(box_width) * AREA_W'(box_height);
            index_reg       <= idx_base;
        end
        if (finish)
        begin
            keep_reg       <= keep_now;
            box_index_reg  <= index_reg;
            kept_total_reg <= TOTAL_W'(kept_count_next);
            overflow_reg   <= keep_now && !store_now;
        end
    end

    // kept store
    assign wr_entry.area = cand_area_reg;
    assign wr_entry.box  = cand_reg;

    gbos_ram #(
        .WIDTH ($bits(kept_entry_t)),
        .DEPTH (MAX_KEPT),
        .AW    (KEPT_AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (finish && store_now),
        .wr_addr (kept_count_reg[KEPT_AW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (issue),
        .rd_addr (scan_cnt_reg[KEPT_AW-1:0]),
        .rd_data (rd_entry)
    );

    // shared compare pipeline
    gbos_overlap_unit u_unit (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (rd_valid_reg),
        .entry       (rd_entry),
        .cand        (cand_reg),
        .cand_area   (cand_area_reg),
        .thr         (thr_reg),
        .stat        (stat)
    );

    assign out_valid      = out_valid_reg;
    assign keep           = keep_reg;
    assign box_index      = box_index_reg;
    assign kept_total     = kept_total_reg;
    assign store_overflow = overflow_reg;

    // store count stays within capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_count_reg <= CNT_W'(MAX_KEPT))
        else $error("kept count beyond store capacity");

    // reads only touch written entries
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (scan_cnt_reg < kept_count_reg))
        else $error("kept store read beyond kept count");

    // result is only formed once every compare has come back
    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> (!stat.busy && !rd_valid_reg))
        else $error("result formed with compares in flight");

    // overflow only for a kept box with a full store
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && store_overflow) |-> (keep && kept_total == TOTAL_W'(MAX_KEPT)))
        else $error("overflow flagged without a full store");

endmodule
